[rtl/core/lmau_pkg.sv]
`default_nettype none

package lmau_pkg;

	// Register file geometry
	localparam int NUM_REGS = 16;
	localparam int REG_W    = $clog2(NUM_REGS);
	localparam int DATA_W   = 32;

	localparam logic [REG_W-1:0]  PC_INDEX = REG_W'(15);
	localparam logic [DATA_W-1:0] PC_STEP  = DATA_W'(4);

	// Instruction field positions
	localparam int OP_HI   = 22;
	localparam int OP_LO   = 20;
	localparam int RN_HI   = 19;
	localparam int RN_LO   = 16;
	localparam int RDLO_HI = 15;
	localparam int RDLO_LO = 12;
	localparam int RDHI_HI = 11;
	localparam int RDHI_LO = 8;
	localparam int RM_HI   = 3;
	localparam int RM_LO   = 0;

	// Command codes
	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_READ  = 2'd1,
		CMD_EXEC  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	// Long multiply opcodes (instruction bits 22:20)
	localparam logic [2:0] OP_SMULL = 3'b000;
	localparam logic [2:0] OP_UMULL = 3'b010;
	localparam logic [2:0] OP_SMLAL = 3'b100;
	localparam logic [2:0] OP_UMLAL = 3'b110;

endpackage

`default_nettype wire

[rtl/core/long_multiply_accumulate_unit.sv]
`default_nettype none

// Long multiply-accumulate unit with a sixteen-entry 32-bit register file
// (register 15 is the program counter). One transaction is processed at a
// time: in_stall is low only while the unit is idle. A register write or
// read goes from acceptance to the output load and then back to idle. An
// execute steps through issue of the Rn/Rm read, multiply, accumulate, one
// register-file write each for RdLo, RdHi and the program counter, then the
// output load. The single write port of the register memory is why the three
// writes take separate steps. The result sits in an output register, so a
// stalled result does not hold back acceptance of the next input
// transaction; it only holds that transaction in its final cycle until the
// output register frees. Registers read as zero after reset until written;
// there is no clearing pass.
module long_multiply_accumulate_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [3:0]  reg_index,
	input  logic [31:0] write_value,
	input  logic [31:0] instruction,
	input  logic        in_it_block,
	input  logic        condition_passed,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] read_value,
	output logic        result_written,
	output logic        it_advance,
	output logic        unsupported
);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_MUL  = 7'b0000010,
		ST_ACC  = 7'b0000100,
		ST_WLO  = 7'b0001000,
		ST_WHI  = 7'b0010000,
		ST_WPC  = 7'b0100000,
		ST_FIN  = 7'b1000000
	} state_t;

	state_t state_q;

	// Register memory and its per-entry valid bits
	logic [lmau_pkg::DATA_W-1:0]   rf_mem [lmau_pkg::NUM_REGS];
	logic [lmau_pkg::NUM_REGS-1:0] vld_q;
	logic [lmau_pkg::DATA_W-1:0]   rda_q, rdb_q;
	logic                          rda_vld_q, rdb_vld_q;
	logic [lmau_pkg::DATA_W-1:0]   rda, rdb;

	logic                          rd_en;
	logic [lmau_pkg::REG_W-1:0]    rda_addr, rdb_addr;
	logic                          mem_we;
	logic [lmau_pkg::REG_W-1:0]    mem_waddr;
	logic [lmau_pkg::DATA_W-1:0]   mem_wdata;

	// Per-transaction state
	lmau_pkg::cmd_t                cmd_q;
	logic [lmau_pkg::REG_W-1:0]    rdlo_q, rdhi_q;
	logic                          sgn_q, acc_en_q;
	logic                          wr_en_q, adv_q, unsup_q;
	logic [63:0]                   prod_q, sum_q;
	logic [lmau_pkg::DATA_W-1:0]   pc_q;

	// Output register
	logic                          out_valid_q;
	logic [lmau_pkg::DATA_W-1:0]   read_value_q;
	logic                          written_out_q, adv_out_q, unsup_out_q;

	logic                          accept;
	logic [2:0]                    op;
	logic                          op_ok;
	logic                          is_exec;
	logic signed [32:0]            mul_a, mul_b;
	logic signed [65:0]            mul_full;
	logic [lmau_pkg::DATA_W-1:0]   pc_base;
	logic                          out_free;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	// Opcode decode at acceptance
	assign op      = instruction[lmau_pkg::OP_HI:lmau_pkg::OP_LO];
	assign op_ok   = (op == lmau_pkg::OP_SMULL) || (op == lmau_pkg::OP_UMULL) ||
	                 (op == lmau_pkg::OP_SMLAL) || (op == lmau_pkg::OP_UMLAL);
	assign is_exec = (lmau_pkg::cmd_t'(command) == lmau_pkg::CMD_EXEC);

	// Unwritten entries read as zero
	assign rda = rda_vld_q ? rda_q : '0;
	assign rdb = rdb_vld_q ? rdb_q : '0;

	// Read port addressing
	always_comb begin
		rd_en    = 1'b0;
		rda_addr = reg_index;
		rdb_addr = instruction[lmau_pkg::RM_HI:lmau_pkg::RM_LO];
		unique case (state_q)
			ST_IDLE: begin
				rd_en = accept;
				if (is_exec) begin
					rda_addr = instruction[lmau_pkg::RN_HI:lmau_pkg::RN_LO];
				end
			end
			ST_MUL: begin
				rd_en    = 1'b1;
				rda_addr = rdlo_q;
				rdb_addr = rdhi_q;
			end
			ST_ACC: begin
				rd_en    = 1'b1;
				rda_addr = lmau_pkg::PC_INDEX;
				rdb_addr = lmau_pkg::PC_INDEX;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// Write port: one destination per cycle
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = reg_index;
		mem_wdata = write_value;
		unique case (state_q)
			ST_IDLE: begin
				mem_we = accept && (lmau_pkg::cmd_t'(command) == lmau_pkg::CMD_WRITE);
			end
			ST_WLO: begin
				mem_we    = wr_en_q;
				mem_waddr = rdlo_q;
				mem_wdata = sum_q[31:0];
			end
			ST_WHI: begin
				mem_we    = wr_en_q;
				mem_waddr = rdhi_q;
				mem_wdata = sum_q[63:32];
			end
			ST_WPC: begin
				mem_we    = 1'b1;
				mem_waddr = lmau_pkg::PC_INDEX;
				mem_wdata = pc_q;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Register memory, registered reads
	always_ff @(posedge clk) begin
		if (mem_we) begin
			rf_mem[mem_waddr] <= mem_wdata;
		end
		if (rd_en) begin
			rda_q <= rf_mem[rda_addr];
			rdb_q <= rf_mem[rdb_addr];
		end
	end

	// Valid bits stand in for the reset value of the register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rda_vld_q <= 1'b0;
			rdb_vld_q <= 1'b0;
		end else begin
			if (mem_we) begin
				vld_q[mem_waddr] <= 1'b1;
			end
			if (rd_en) begin
				rda_vld_q <= vld_q[rda_addr];
				rdb_vld_q <= vld_q[rdb_addr];
			end
		end
	end

	// Multiplier: 33x33 signed covers both signed and unsigned operands
	assign mul_a    = {sgn_q & rda[31], rda};
	assign mul_b    = {sgn_q & rdb[31], rdb};
	assign mul_full = mul_a * mul_b;

	// Program counter base: a destination write to the PC lands first
	always_comb begin
		pc_base = rda;
		if (wr_en_q && (rdhi_q == lmau_pkg::PC_INDEX)) begin
			pc_base = sum_q[63:32];
		end else if (wr_en_q && (rdlo_q == lmau_pkg::PC_INDEX)) begin
			pc_base = sum_q[31:0];
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= lmau_pkg::cmd_t'(command);
			rdlo_q   <= instruction[lmau_pkg::RDLO_HI:lmau_pkg::RDLO_LO];
			rdhi_q   <= instruction[lmau_pkg::RDHI_HI:lmau_pkg::RDHI_LO];
			sgn_q    <= !op[1];
			acc_en_q <= op[2];
			wr_en_q  <= is_exec && op_ok && (!in_it_block || condition_passed);
			adv_q    <= is_exec && op_ok && in_it_block;
			unsup_q  <= is_exec && !op_ok;
		end
		if (state_q == ST_MUL) begin
			prod_q <= mul_full[63:0];
		end
		if (state_q == ST_ACC) begin
			sum_q <= prod_q + (acc_en_q ? {rdb, rda} : 64'd0);
		end
		if (state_q == ST_WLO) begin
			pc_q <= pc_base + lmau_pkg::PC_STEP;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= (is_exec && op_ok) ? ST_MUL : ST_FIN;
					end
				end
				ST_MUL:  state_q <= ST_ACC;
				ST_ACC:  state_q <= ST_WLO;
				ST_WLO:  state_q <= ST_WHI;
				ST_WHI:  state_q <= ST_WPC;
				ST_WPC:  state_q <= ST_FIN;
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			read_value_q  <= (cmd_q == lmau_pkg::CMD_READ) ? rda : '0;
			written_out_q <= wr_en_q;
			adv_out_q     <= adv_q;
			unsup_out_q   <= unsup_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign read_value     = read_value_q;
	assign result_written = written_out_q;
	assign it_advance     = adv_out_q;
	assign unsupported    = unsup_out_q;

endmodule

`default_nettype wire

[rtl/core/lmau_checker.sv]
`default_nettype none

// Port-level checks for the long multiply-accumulate unit
module lmau_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [1:0]  command,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] read_value,
	input logic        result_written,
	input logic        it_advance,
	input logic        unsupported
);

	// One transaction at a time: an accepted input blocks the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted back to back");

	// An unsupported opcode leaves no other trace in the result
	a_unsup_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && unsupported |-> !result_written && !it_advance && read_value == 32'd0)
		else $error("unsupported result carries other flags");

	// A register write by execute never reports read data or an unknown op
	a_written_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_written |-> read_value == 32'd0 && !unsupported)
		else $error("written result carries read data or unsupported flag");

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(read_value) &&
			$stable(result_written) && $stable(it_advance) && $stable(unsupported))
		else $error("stalled result changed");

	// A non-execute command cannot produce execute flags right after acceptance
	a_cmd_flags: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && command != lmau_pkg::CMD_EXEC |=>
			!(out_valid && $rose(out_valid) && (result_written || it_advance)))
		else $error("execute flags on non-execute command");

endmodule

bind long_multiply_accumulate_unit lmau_checker u_lmau_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.command        (command),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.read_value     (read_value),
	.result_written (result_written),
	.it_advance     (it_advance),
	.unsupported    (unsupported)
);

`default_nettype wire

[tb/tb_long_multiply_accumulate_unit.sv]
`timescale 1ns / 100ps

module tb_long_multiply_accumulate_unit;

	import lmau_pkg::*;

	// One input transaction as seen on the request side
	typedef struct packed {
		cmd_t        cmd;
		logic [3:0]  idx;
		logic [31:0] wval;
		logic [31:0] instr;
		logic        in_it;
		logic        cond_ok;
	} lmau_item_t;

	// One response transaction
	typedef struct packed {
		logic [31:0] read_value;
		logic        written;
		logic        advance;
		logic        unsupported;
	} lmau_response_t;

	logic        clk;
	logic        arst_n           = 1'b0;
	logic        in_valid         = 1'b0;
	logic        in_stall;
	logic [1:0]  command          = CMD_NONE;
	logic [3:0]  reg_index        = '0;
	logic [31:0] write_value      = '0;
	logic [31:0] instruction      = '0;
	logic        in_it_block      = 1'b0;
	logic        condition_passed = 1'b0;
	logic        out_valid;
	logic        out_stall        = 1'b0;
	logic [31:0] read_value;
	logic        result_written;
	logic        it_advance;
	logic        unsupported;

	// Shadow copy of the register file and responses still owed by the unit
	logic [31:0]    shadow_regs [NUM_REGS];
	lmau_response_t queued_responses [$];

	int error_count = 0;
	int stall_left  = 0;
	bit idle_en     = 1'b1;

	long_multiply_accumulate_unit dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.command          (command),
		.reg_index        (reg_index),
		.write_value      (write_value),
		.instruction      (instruction),
		.in_it_block      (in_it_block),
		.condition_passed (condition_passed),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.read_value       (read_value),
		.result_written   (result_written),
		.it_advance       (it_advance),
		.unsupported      (unsupported)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Apply one command to the shadow register file, return the response
	function automatic lmau_response_t perform_command(input lmau_item_t it);
		lmau_response_t rsp;
		logic [2:0]     op;
		logic [3:0]     rn, rdlo, rdhi, rm;
		logic [63:0]    a, b, acc;
		logic           sgn;
		rsp  = '0;
		op   = it.instr[OP_HI:OP_LO];
		rn   = it.instr[RN_HI:RN_LO];
		rdlo = it.instr[RDLO_HI:RDLO_LO];
		rdhi = it.instr[RDHI_HI:RDHI_LO];
		rm   = it.instr[RM_HI:RM_LO];
		case (it.cmd)
			CMD_WRITE: shadow_regs[it.idx] = it.wval;
			CMD_READ:  rsp.read_value = shadow_regs[it.idx];
			CMD_EXEC: begin
				if (op != OP_SMULL && op != OP_UMULL && op != OP_SMLAL && op != OP_UMLAL) begin
					rsp.unsupported = 1'b1;
				end else begin
					sgn = (op == OP_SMULL || op == OP_SMLAL);
					a   = {{32{sgn & shadow_regs[rn][31]}}, shadow_regs[rn]};
					b   = {{32{sgn & shadow_regs[rm][31]}}, shadow_regs[rm]};
					acc = a * b;
					// all sources are read before any destination is written
					if (op == OP_SMLAL || op == OP_UMLAL)
						acc = acc + {shadow_regs[rdhi], shadow_regs[rdlo]};
					if (!it.in_it || it.cond_ok) begin
						shadow_regs[rdlo] = acc[31:0];
						shadow_regs[rdhi] = acc[63:32];
						rsp.written = 1'b1;
					end
					rsp.advance = it.in_it;
					shadow_regs[PC_INDEX] = shadow_regs[PC_INDEX] + PC_STEP;
				end
			end
			default: ;
		endcase
		return rsp;
	endfunction

	function automatic logic [31:0] encode_mul(input logic [2:0] op, input logic [3:0] rdlo,
		input logic [3:0] rdhi, input logic [3:0] rn, input logic [3:0] rm);
		logic [31:0] w;
		w = '0;
		w[OP_HI:OP_LO]     = op;
		w[RN_HI:RN_LO]     = rn;
		w[RDLO_HI:RDLO_LO] = rdlo;
		w[RDHI_HI:RDHI_LO] = rdhi;
		w[RM_HI:RM_LO]     = rm;
		return w;
	endfunction

	// Data word biased toward the arithmetic corners
	function automatic logic [31:0] random_word();
		case ($urandom_range(0, 7))
			0:       return 32'h0000_0000;
			1:       return 32'hFFFF_FFFF;
			2:       return 32'h8000_0000;
			3:       return 32'h7FFF_FFFF;
			4:       return 32'h0000_0001;
			default: return $urandom();
		endcase
	endfunction

	// Random long multiply encoding with a legal opcode, other bits random
	function automatic logic [31:0] random_long_mul();
		logic [31:0] w;
		w = $urandom();
		case ($urandom_range(0, 3))
			0:       w[OP_HI:OP_LO] = OP_SMULL;
			1:       w[OP_HI:OP_LO] = OP_UMULL;
			2:       w[OP_HI:OP_LO] = OP_SMLAL;
			default: w[OP_HI:OP_LO] = OP_UMLAL;
		endcase
		return w;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		error_count++;
	endtask

	// Drive one request transaction and hold it until accepted
	task automatic send_item(input cmd_t cmd, input logic [3:0] idx, input logic [31:0] wval,
		input logic [31:0] instr, input logic in_it, input logic cond_ok);
		lmau_item_t it;
		int         gap;
		it  = '{cmd: cmd, idx: idx, wval: wval, instr: instr, in_it: in_it, cond_ok: cond_ok};
		gap = idle_en ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid         <= 1'b1;
		command          <= cmd;
		reg_index        <= idx;
		write_value      <= wval;
		instruction      <= instr;
		in_it_block      <= in_it;
		condition_passed <= cond_ok;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		queued_responses.push_back(perform_command(it));
	endtask

	// Compare one accepted response with the oldest one owed
	task automatic check_response();
		lmau_response_t want;
		if (queued_responses.size() == 0) begin
			report_mismatch($sformatf("response with nothing pending, read_value=%h",
				read_value));
			return;
		end
		want = queued_responses.pop_front();
		if (read_value !== want.read_value)
			report_mismatch($sformatf("read_value %h, want %h", read_value, want.read_value));
		if (result_written !== want.written)
			report_mismatch($sformatf("result_written %b, want %b", result_written,
				want.written));
		if (it_advance !== want.advance)
			report_mismatch($sformatf("it_advance %b, want %b", it_advance, want.advance));
		if (unsupported !== want.unsupported)
			report_mismatch($sformatf("unsupported %b, want %b", unsupported,
				want.unsupported));
	endtask

	// Response side: check each transaction, then hold stall for a random count
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			check_response();
			stall_left = idle_en ? $urandom_range(0, 5) : 0;
		end
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic test_register_access();
		send_item(CMD_WRITE, 4'd1, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b0);
		send_item(CMD_WRITE, 4'd2, 32'h8000_0000, 32'h0, 1'b0, 1'b0);
		send_item(CMD_WRITE, 4'd0, 32'h0000_0000, 32'h0, 1'b0, 1'b0);
		send_item(CMD_READ,  4'd1, 32'h0, 32'h0, 1'b0, 1'b0);
		send_item(CMD_READ,  4'd15, 32'h0, 32'h0, 1'b0, 1'b0);
	endtask

	task automatic test_multiply_ops();
		send_item(CMD_EXEC, 4'd0, 32'h0, encode_mul(OP_SMULL, 4'd4, 4'd5, 4'd1, 4'd2), 1'b0, 1'b0);
		send_item(CMD_EXEC, 4'd0, 32'h0, encode_mul(OP_UMULL, 4'd6, 4'd7, 4'd1, 4'd1), 1'b0, 1'b0);
		send_item(CMD_EXEC, 4'd0, 32'h0, encode_mul(OP_SMLAL, 4'd4, 4'd5, 4'd2, 4'd2), 1'b0, 1'b0);
		send_item(CMD_EXEC, 4'd0, 32'h0, encode_mul(OP_UMLAL, 4'd6, 4'd7, 4'd1, 4'd2), 1'b0, 1'b0);
		for (int r = 4; r <= 7; r++)
			send_item(CMD_READ, 4'(r), 32'h0, 32'h0, 1'b0, 1'b0);
	endtask

	task automatic test_special_cases();
		// unknown command with every field at its maximum
		send_item(CMD_NONE, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
		// undefined opcode inside an IT block: no write, no advance
		send_item(CMD_EXEC, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
		// all-zero encoding is a signed multiply of r0 by itself
		send_item(CMD_EXEC, 4'h0, 32'h0, 32'h0, 1'b0, 1'b0);
		// RdLo == RdHi == Rn == Rm: sources read first, high word wins
		send_item(CMD_EXEC, 4'd0, 32'h0, encode_mul(OP_UMLAL, 4'd1, 4'd1, 4'd1, 4'd1), 1'b0, 1'b0);
		send_item(CMD_READ, 4'd1, 32'h0, 32'h0, 1'b0, 1'b0);
		// high destination is the program counter, then the PC step
		send_item(CMD_EXEC, 4'd0, 32'h0, encode_mul(OP_SMULL, 4'd9, 4'd15, 4'd2, 4'd2), 1'b0, 1'b0);
		send_item(CMD_READ, 4'd15, 32'h0, 32'h0, 1'b0, 1'b0);
		// IT block: failed condition skips the write, still advances
		send_item(CMD_EXEC, 4'd0, 32'h0, encode_mul(OP_UMULL, 4'd10, 4'd11, 4'd2, 4'd2), 1'b1, 1'b0);
		send_item(CMD_READ, 4'd10, 32'h0, 32'h0, 1'b0, 1'b0);
		send_item(CMD_EXEC, 4'd0, 32'h0, encode_mul(OP_UMULL, 4'd10, 4'd11, 4'd2, 4'd2), 1'b1, 1'b1);
		// outside an IT block the condition input is ignored
		send_item(CMD_EXEC, 4'd0, 32'h0, encode_mul(OP_SMLAL, 4'd10, 4'd11, 4'd1, 4'd2), 1'b0, 1'b0);
	endtask

	// Mixed traffic; every field is random even where the command ignores it
	task automatic test_random_traffic(input int count);
		int          pick;
		logic [31:0] instr;
		for (int n = 0; n < count; n++) begin
			pick  = $urandom_range(0, 99);
			instr = ($urandom_range(0, 9) == 0) ? $urandom() : random_long_mul();
			if (pick < 25)
				send_item(CMD_WRITE, 4'($urandom()), random_word(), instr,
					1'($urandom()), 1'($urandom()));
			else if (pick < 45)
				send_item(CMD_READ, 4'($urandom()), $urandom(), instr,
					1'($urandom()), 1'($urandom()));
			else if (pick < 96)
				send_item(CMD_EXEC, 4'($urandom()), $urandom(), instr,
					1'($urandom()), 1'($urandom()));
			else
				send_item(CMD_NONE, 4'($urandom()), $urandom(), $urandom(),
					1'($urandom()), 1'($urandom()));
		end
	endtask

	// Same traffic with no gaps on either side
	task automatic test_back_to_back_traffic(input int count);
		idle_en = 1'b0;
		test_random_traffic(count);
		idle_en = 1'b1;
	endtask

	initial begin
		for (int r = 0; r < NUM_REGS; r++)
			shadow_regs[r] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_register_access();
		test_multiply_ops();
		test_special_cases();
		test_random_traffic(650);
		test_back_to_back_traffic(250);
		test_random_traffic(600);

		in_valid <= 1'b0;
		while (queued_responses.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Watchdog
	initial begin
		#3_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
